>>> src/blq_pkg.sv
// Shared types and helpers for the billboard line quad expander.
`timescale 1ns / 1ps
`default_nettype none
package blq_pkg;

  // Depth of the queue between the front sequencer and the vertex emitter
  localparam int QDepth = 2;

  // Front sequencer states
  typedef enum logic [3:0] {
    FS_IDLE,
    FS_CROSS,
    FS_ABS,
    FS_NORM,
    FS_SQ,
    FS_SQRT,
    FS_DIV,
    FS_SCALE,
    FS_PUSH
  } front_state_t;

  // One finished line: endpoints, signed offset vector, degenerate flag
  typedef struct packed {
    logic [2:0][31:0] st;
    logic [2:0][31:0] en;
    logic [2:0][32:0] offs;
    logic             degen;
  } line_entry_t;

  // Clamp a 34-bit signed sum to the 32-bit signed range
  function automatic logic [31:0] sat32(input logic signed [33:0] v);
    logic [31:0] r;
    if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
      r = v[31:0];
    end else if (v[33]) begin
      r = 32'h8000_0000;
    end else begin
      r = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/blq_front.sv
// Front: accepts lines and works out the side offset vector with a shared multiplier.
`timescale 1ns / 1ps
`default_nettype none
module blq_front (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_valid,
  output logic                      in_stall,
  input  wire  [31:0]               start_x,
  input  wire  [31:0]               start_y,
  input  wire  [31:0]               start_z,
  input  wire  [31:0]               end_x,
  input  wire  [31:0]               end_y,
  input  wire  [31:0]               end_z,
  input  wire  [30:0]               offset_width,
  input  wire  [31:0]               eye_x,
  input  wire  [31:0]               eye_y,
  input  wire  [31:0]               eye_z,
  output logic                      q_push,
  output blq_pkg::line_entry_t      q_data,
  input  wire                       q_full
);
  import blq_pkg::*;

  front_state_t state, state_next;

  // Input holding register
  logic              pend_valid;
  logic [2:0][31:0]  p_st, p_en, p_eye;
  logic [30:0]       p_w;
  logic              take;

  // Working registers
  logic [2:0][31:0]         st, en;
  logic signed [31:0]       e [3];
  logic signed [32:0]       d [3];
  logic [30:0]              wid;
  logic signed [66:0]       c [3];
  logic [65:0]              mg [3];
  logic                     neg [3];
  logic                     degen;
  logic [61:0]              sumsq, rad;
  logic [33:0]              rem;
  logic [30:0]              root, nb;
  logic [32:0]              dr [3];
  logic [30:0]              q [3];
  logic [2:0][32:0]         offs;
  logic [4:0]               cnt;

  // Shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod;

  logic [65:0] orv;
  logic [33:0] rem_sh, trial;
  logic [32:0] divisor;
  logic [61:0] sq_sum, sc_sum;
  logic [31:0] amag;

  assign in_stall = pend_valid;
  assign take     = (state == FS_IDLE) && pend_valid;
  assign orv      = mg[0] | mg[1] | mg[2];

  // Input holding register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_valid && !pend_valid) begin
      pend_valid <= 1'b1;
    end else if (take) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !pend_valid) begin
      p_st  <= {start_z, start_y, start_x};
      p_en  <= {end_z, end_y, end_x};
      p_eye <= {eye_z, eye_y, eye_x};
      p_w   <= offset_width;
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and queue push
  always_comb begin
    state_next = state;
    q_push     = 1'b0;
    case (state)
      FS_IDLE:  if (take) state_next = FS_CROSS;
      FS_CROSS: if (cnt == 5'd6) state_next = FS_ABS;
      FS_ABS:   state_next = FS_NORM;
      FS_NORM: begin
        if (orv == '0) state_next = FS_PUSH;
        else if (orv[65]) state_next = FS_SQ;
      end
      FS_SQ:    if (cnt == 5'd3) state_next = FS_SQRT;
      FS_SQRT:  if (cnt == 5'd30) state_next = FS_DIV;
      FS_DIV:   if (cnt == 5'd31) state_next = FS_SCALE;
      FS_SCALE: if (cnt == 5'd3) state_next = FS_PUSH;
      FS_PUSH: begin
        if (!q_full) begin
          q_push     = 1'b1;
          state_next = FS_IDLE;
        end
      end
      default:  state_next = FS_IDLE;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      FS_CROSS: begin
        case (cnt)
          5'd0: begin mul_a = 33'(e[1]); mul_b = d[2]; end
          5'd1: begin mul_a = 33'(e[2]); mul_b = d[1]; end
          5'd2: begin mul_a = 33'(e[2]); mul_b = d[0]; end
          5'd3: begin mul_a = 33'(e[0]); mul_b = d[2]; end
          5'd4: begin mul_a = 33'(e[0]); mul_b = d[1]; end
          5'd5: begin mul_a = 33'(e[1]); mul_b = d[0]; end
          default: ;
        endcase
      end
      FS_SQ: begin
        case (cnt)
          5'd0: begin mul_a = {3'b0, mg[0][65:36]}; mul_b = {3'b0, mg[0][65:36]}; end
          5'd1: begin mul_a = {3'b0, mg[1][65:36]}; mul_b = {3'b0, mg[1][65:36]}; end
          5'd2: begin mul_a = {3'b0, mg[2][65:36]}; mul_b = {3'b0, mg[2][65:36]}; end
          default: ;
        endcase
      end
      FS_SCALE: begin
        case (cnt)
          5'd0: begin mul_a = {2'b0, wid}; mul_b = {2'b0, q[0]}; end
          5'd1: begin mul_a = {2'b0, wid}; mul_b = {2'b0, q[1]}; end
          5'd2: begin mul_a = {2'b0, wid}; mul_b = {2'b0, q[2]}; end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Square-root step, divide step and scaling round
  assign rem_sh  = {rem[31:0], rad[61:60]};
  assign trial   = {1'b0, root, 2'b01};
  assign divisor = {1'b0, root, 1'b0};
  assign sq_sum  = sumsq + prod[61:0];
  assign sc_sum  = prod[61:0] + 62'h2000_0000;
  assign amag    = sc_sum[61:30];

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state_next != state) begin
      cnt <= '0;
    end else begin
      cnt <= cnt + 5'd1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      FS_IDLE: begin
        if (take) begin
          st  <= p_st;
          en  <= p_en;
          wid <= p_w;
          for (int i = 0; i < 3; i++) begin
            e[i] <= $signed(p_eye[i]);
            d[i] <= 33'($signed(p_en[i])) - 33'($signed(p_st[i]));
          end
        end
      end
      FS_CROSS: begin
        case (cnt)
          5'd1: c[0] <= 67'(prod);
          5'd2: c[0] <= c[0] - 67'(prod);
          5'd3: c[1] <= 67'(prod);
          5'd4: c[1] <= c[1] - 67'(prod);
          5'd5: c[2] <= 67'(prod);
          5'd6: c[2] <= c[2] - 67'(prod);
          default: ;
        endcase
      end
      FS_ABS: begin
        degen <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          neg[i] <= c[i][66];
          mg[i]  <= c[i][66] ? 66'(-c[i]) : 66'(c[i]);
        end
      end
      FS_NORM: begin
        // bring the largest magnitude up to the top bit
        if (orv == '0) begin
          degen <= 1'b1;
          offs  <= '0;
        end else if (orv[65]) begin
          sumsq <= '0;
        end else if (orv[65:58] == 8'd0) begin
          for (int i = 0; i < 3; i++) mg[i] <= {mg[i][57:0], 8'd0};
        end else begin
          for (int i = 0; i < 3; i++) mg[i] <= {mg[i][64:0], 1'b0};
        end
      end
      FS_SQ: begin
        if (cnt != 5'd0) sumsq <= sq_sum;
        if (cnt == 5'd3) begin
          rad  <= sq_sum;
          rem  <= '0;
          root <= '0;
        end
      end
      FS_SQRT: begin
        // one result bit per cycle
        if (rem_sh >= trial) begin
          rem  <= rem_sh - trial;
          root <= {root[29:0], 1'b1};
        end else begin
          rem  <= rem_sh;
          root <= {root[29:0], 1'b0};
        end
        rad <= {rad[59:0], 2'b00};
      end
      FS_DIV: begin
        // three lanes share the divisor 2*len; the low numerator bits are len
        if (cnt == 5'd0) begin
          nb <= root;
          for (int i = 0; i < 3; i++) begin
            dr[i] <= {3'b0, mg[i][65:36]};
            q[i]  <= '0;
          end
        end else begin
          nb <= {nb[29:0], 1'b0};
          for (int i = 0; i < 3; i++) begin
            if ({dr[i][31:0], nb[30]} >= divisor) begin
              dr[i] <= {dr[i][31:0], nb[30]} - divisor;
              q[i]  <= {q[i][29:0], 1'b1};
            end else begin
              dr[i] <= {dr[i][31:0], nb[30]};
              q[i]  <= {q[i][29:0], 1'b0};
            end
          end
        end
      end
      FS_SCALE: begin
        case (cnt)
          5'd1: offs[0] <= neg[0] ? 33'(-$signed({1'b0, amag})) : {1'b0, amag};
          5'd2: offs[1] <= neg[1] ? 33'(-$signed({1'b0, amag})) : {1'b0, amag};
          5'd3: offs[2] <= neg[2] ? 33'(-$signed({1'b0, amag})) : {1'b0, amag};
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign q_data.st    = st;
  assign q_data.en    = en;
  assign q_data.offs  = offs;
  assign q_data.degen = degen;

endmodule
`default_nettype wire

>>> src/blq_queue.sv
// Short queue of finished lines between the front and the vertex emitter.
`timescale 1ns / 1ps
`default_nettype none
module blq_queue (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   push,
  input  blq_pkg::line_entry_t  wr_data,
  output logic                  full,
  input  wire                   pop,
  output blq_pkg::line_entry_t  rd_data,
  output logic                  not_empty
);
  import blq_pkg::*;

  localparam int PtrW = $clog2(QDepth);

  line_entry_t       mem [QDepth];
  logic [PtrW-1:0]   wr_ptr, rd_ptr;
  logic [PtrW:0]     count;

  assign full      = (count == (PtrW+1)'(QDepth));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

>>> src/blq_back.sv
// Back: emits the four strip corners of each queued line through an output register.
`timescale 1ns / 1ps
`default_nettype none
module blq_back (
  input  wire                   clk,
  input  wire                   rst,
  input  blq_pkg::line_entry_t  q_data,
  input  wire                   q_valid,
  output logic                  q_pop,
  output logic                  out_valid,
  input  wire                   out_stall,
  output logic [1:0]            vertex_index,
  output logic [31:0]           pos_x,
  output logic [31:0]           pos_y,
  output logic [31:0]           pos_z,
  output logic                  degenerate,
  output logic                  last_vertex
);
  import blq_pkg::*;

  line_entry_t        cur;
  logic               have_cur;
  logic [1:0]         k;
  logic               load_out;
  logic [2:0][31:0]   vpos;
  logic signed [33:0] base, offv;

  assign load_out = have_cur && (!out_valid || !out_stall);
  assign q_pop    = q_valid && (!have_cur || (load_out && k == 2'd3));

  // Corner k: odd picks end, upper half adds the offset
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      base    = 34'($signed(k[0] ? cur.en[i] : cur.st[i]));
      offv    = 34'($signed(cur.offs[i]));
      vpos[i] = sat32(k[1] ? base + offv : base - offv);
    end
  end

  // Current line and corner counter
  always_ff @(posedge clk) begin
    if (rst) begin
      have_cur <= 1'b0;
      k        <= '0;
    end else if (q_pop) begin
      have_cur <= 1'b1;
      k        <= '0;
    end else if (load_out) begin
      k <= k + 2'd1;
      if (k == 2'd3) have_cur <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_data;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      vertex_index <= k;
      pos_x        <= vpos[0];
      pos_y        <= vpos[1];
      pos_z        <= vpos[2];
      degenerate   <= cur.degen;
      last_vertex  <= (k == 2'd3);
    end
  end

endmodule
`default_nettype wire

>>> src/billboard_line_quad_expand_core.sv
// A line goes from the input holding register through the front and the queue to the output
// register; its other three corners follow one per cycle while out_stall is low.
// The rate for lines that are not degenerate is set by the front's normalize shifts,
// bit-serial square root and three-lane divider; the holding register takes the next line early.
// Reset (rst, synchronous) empties the holding register, the queue and the output.
`timescale 1ns / 1ps
`default_nettype none
module billboard_line_quad_expand_core (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire  [31:0] start_x,
  input  wire  [31:0] start_y,
  input  wire  [31:0] start_z,
  input  wire  [31:0] end_x,
  input  wire  [31:0] end_y,
  input  wire  [31:0] end_z,
  input  wire  [30:0] offset_width,
  input  wire  [31:0] eye_x,
  input  wire  [31:0] eye_y,
  input  wire  [31:0] eye_z,
  output logic        out_valid,
  input  wire         out_stall,
  output logic [1:0]  vertex_index,
  output logic [31:0] pos_x,
  output logic [31:0] pos_y,
  output logic [31:0] pos_z,
  output logic        degenerate,
  output logic        last_vertex
);
  import blq_pkg::*;

  line_entry_t push_data, pop_data;
  logic        q_push, q_full, q_pop, q_valid;

  blq_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .start_x      (start_x),
    .start_y      (start_y),
    .start_z      (start_z),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_z        (end_z),
    .offset_width (offset_width),
    .eye_x        (eye_x),
    .eye_y        (eye_y),
    .eye_z        (eye_z),
    .q_push       (q_push),
    .q_data       (push_data),
    .q_full       (q_full)
  );

  blq_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .wr_data   (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .rd_data   (pop_data),
    .not_empty (q_valid)
  );

  blq_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_data       (pop_data),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .degenerate   (degenerate),
    .last_vertex  (last_vertex)
  );

  // The last flag marks corner three only
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_vertex == (vertex_index == 2'd3)))
    else $error("last flag does not match corner index");

  // Corners of one line follow without a gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_vertex |=> out_valid)
    else $error("gap inside a quad");

  // Corner index steps by one within a quad
  a_idx_step: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_vertex |=>
      vertex_index == $past(vertex_index) + 2'd1)
    else $error("corner index skipped");

endmodule
`default_nettype wire

>>> sim/blq_checker.sv
// Checker for the billboard line quad expander: predicts the four corners per line and compares.
`timescale 1ns / 1ps
`default_nettype none
module blq_checker (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  input  wire         in_stall,
  input  wire  [31:0] start_x,
  input  wire  [31:0] start_y,
  input  wire  [31:0] start_z,
  input  wire  [31:0] end_x,
  input  wire  [31:0] end_y,
  input  wire  [31:0] end_z,
  input  wire  [30:0] offset_width,
  input  wire  [31:0] eye_x,
  input  wire  [31:0] eye_y,
  input  wire  [31:0] eye_z,
  input  wire         out_valid,
  input  wire         out_stall,
  input  wire  [1:0]  vertex_index,
  input  wire  [31:0] pos_x,
  input  wire  [31:0] pos_y,
  input  wire  [31:0] pos_z,
  input  wire         degenerate,
  input  wire         last_vertex,
  output int          fail_count,
  output int          pending,
  output int          corners_seen,
  output int          degen_seen
);

  typedef struct packed {
    logic [1:0]  idx;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        degen;
    logic        last;
  } corner_t;

  corner_t corner_q[$];

  // Clamp to the 32-bit signed range
  function automatic logic [31:0] clamp32(input logic signed [65:0] v);
    logic [31:0] r;
    if (v > 66'sh7FFF_FFFF) r = 32'h7FFF_FFFF;
    else if (v < -66'sh8000_0000) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // Integer floor square root
  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res, bitv, rem;
    res = 0; bitv = 64'd1 << 62; rem = v;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Work out the four quad corners of one line
  task automatic predict_quad(input logic [31:0] sv[3], input logic [31:0] ev[3],
                              input logic [30:0] w, input logic [31:0] eyev[3]);
    logic signed [33:0] d[3];
    logic signed [67:0] c[3];
    logic [67:0] mg[3];
    logic [63:0] m[3];
    logic [63:0] sumsq, len, s, a;
    logic signed [65:0] add[3], base, val;
    int maxb, nb;
    logic dg;
    corner_t cr;
    for (int i = 0; i < 3; i++) d[i] = $signed(ev[i]) - $signed(sv[i]);
    c[0] = $signed(eyev[1]) * d[2] - $signed(eyev[2]) * d[1];
    c[1] = $signed(eyev[2]) * d[0] - $signed(eyev[0]) * d[2];
    c[2] = $signed(eyev[0]) * d[1] - $signed(eyev[1]) * d[0];
    maxb = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = c[i] < 0 ? -c[i] : c[i];
      nb = 0;
      for (int b = 0; b < 68; b++) if (mg[i][b]) nb = b + 1;
      if (nb > maxb) maxb = nb;
      add[i] = 0;
    end
    dg = (maxb == 0);
    if (!dg) begin
      sumsq = 0;
      for (int i = 0; i < 3; i++) begin
        if (maxb > 30) m[i] = mg[i] >> (maxb - 30);
        else m[i] = mg[i][63:0] << (30 - maxb);
        sumsq = sumsq + m[i] * m[i];
      end
      len = floor_sqrt(sumsq);
      for (int i = 0; i < 3; i++) begin
        s = ((m[i] << 31) + len) / (len * 2);
        a = (64'(w) * s + (64'd1 << 29)) >> 30;
        add[i] = c[i] < 0 ? -$signed({2'b00, a}) : $signed({2'b00, a});
      end
    end
    for (int k = 0; k < 4; k++) begin
      logic [31:0] p[3];
      for (int i = 0; i < 3; i++) begin
        base = (k & 1) ? 66'($signed(ev[i])) : 66'($signed(sv[i]));
        val = (k & 2) ? base + add[i] : base - add[i];
        p[i] = clamp32(val);
      end
      cr = '{idx: 2'(k), x: p[0], y: p[1], z: p[2], degen: dg, last: (k == 3)};
      corner_q.push_back(cr);
    end
  endtask

  // Capture input transfers
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      predict_quad('{start_x, start_y, start_z}, '{end_x, end_y, end_z}, offset_width,
                   '{eye_x, eye_y, eye_z});
    end
  end

  // Compare output transfers
  always @(posedge clk) begin
    corner_t ex;
    if (rst) begin
      fail_count <= 0;
      corners_seen <= 0;
      degen_seen <= 0;
    end else if (out_valid && !out_stall) begin
      corners_seen <= corners_seen + 1;
      if (degenerate) degen_seen <= degen_seen + 1;
      if (corner_q.size() == 0) begin
        $display("%0t: corner transfer with nothing expected (idx %0d)", $time, vertex_index);
        fail_count <= fail_count + 1;
      end else begin
        ex = corner_q.pop_front();
        if (ex != {vertex_index, pos_x, pos_y, pos_z, degenerate, last_vertex}) begin
          $display("%0t: mismatch exp idx=%0d x=%h y=%h z=%h dg=%b last=%b", $time,
                   ex.idx, ex.x, ex.y, ex.z, ex.degen, ex.last);
          $display("%0t:          got idx=%0d x=%h y=%h z=%h dg=%b last=%b", $time,
                   vertex_index, pos_x, pos_y, pos_z, degenerate, last_vertex);
          fail_count <= fail_count + 1;
        end
      end
    end
  end

  always_comb pending = corner_q.size();

endmodule
`default_nettype wire

>>> sim/tb.sv
// Testbench top for the billboard line quad expander: stimulus, stalls and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [31:0] start_x = '0, start_y = '0, start_z = '0;
  logic [31:0] end_x = '0, end_y = '0, end_z = '0;
  logic [30:0] offset_width = '0;
  logic [31:0] eye_x = '0, eye_y = '0, eye_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] vertex_index;
  logic [31:0] pos_x, pos_y, pos_z;
  logic degenerate, last_vertex;
  int fail_count, pending, corners_seen, degen_seen;
  int lines_sent = 0;
  logic hold_phase = 1'b0;

  always #5 clk = ~clk;

  billboard_line_quad_expand_core dut (.*);
  blq_checker chk (.*);

  // Random coordinate: extremes, small values or full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2, 3, 4: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // Offer one line and hold it until the transfer
  task automatic send_line(input logic [31:0] s[3], input logic [31:0] e[3],
                           input logic [30:0] w, input logic [31:0] v[3]);
    start_x <= s[0]; start_y <= s[1]; start_z <= s[2];
    end_x <= e[0]; end_y <= e[1]; end_z <= e[2];
    offset_width <= w;
    eye_x <= v[0]; eye_y <= v[1]; eye_z <= v[2];
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    lines_sent++;
  endtask

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 150) : $urandom_range(0, 3);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic random_line();
    logic [31:0] s[3], e[3], v[3];
    logic [30:0] w;
    for (int i = 0; i < 3; i++) begin
      s[i] = rand_coord(); v[i] = rand_coord();
      e[i] = ($urandom_range(0, 3) == 0) ? rand_coord() : s[i] + $urandom_range(0, 600000);
    end
    case ($urandom_range(0, 12))
      0: e = s;
      1: v = '{32'h0, 32'h0, 32'h0};
      2: begin
        e[0] = s[0] + v[0]; e[1] = s[1] + v[1]; e[2] = s[2] + v[2];
      end
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: w = 31'h7FFF_FFFF;
      1: w = 31'($urandom);
      default: w = 31'($urandom_range(0, 1 << 20));
    endcase
    send_line(s, e, w, v);
  endtask

  // Receiver stalls, with a long hold while the sender keeps offering
  initial begin
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_phase) begin
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        wait (!hold_phase);
      end else if ($urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 30) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(20, 120)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int wait_cnt;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // Directed lines: extremes, degenerate cases, saturation
    send_line('{0, 0, 0}, '{32'h0001_0000, 0, 0}, 31'h0001_0000, '{0, 0, 32'h0001_0000});
    send_line('{5, 6, 7}, '{5, 6, 7}, 31'h7FFF_FFFF, '{1, 2, 3});
    send_line('{0, 0, 0}, '{100, 200, 300}, 31'h0001_0000, '{0, 0, 0});
    send_line('{0, 0, 0}, '{100, 200, 300}, 31'h0001_0000, '{200, 400, 600});
    send_line('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF},
              '{32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF}, 31'h7FFF_FFFF,
              '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000});
    send_line('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000},
              '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000}, 31'h7FFF_FFFF,
              '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF});
    send_line('{32'h7FFF_0000, 0, 0}, '{32'h7FFF_0000, 32'h0001_0000, 0}, 31'h0100_0000,
              '{0, 0, 32'hFFFF_0000});
    send_line('{0, 0, 0}, '{0, 0, 1}, 31'd1, '{1, 0, 0});
    send_line('{1, 2, 3}, '{4, 5, 6}, 31'd0, '{7, 3, 9});
    send_line('{32'h8000_0000, 0, 0}, '{32'h8000_0000, 0, 32'h0001_0000}, 31'h7FFF_FFFF,
              '{32'h0001_0000, 0, 0});
    send_line('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, '{0, 0, 0}, 31'h5555_5555,
              '{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF});
    in_valid <= 1'b0;
    // Random lines with gaps
    for (int n = 0; n < 120; n++) begin
      if (n == 40) begin
        // receiver holds off while lines keep coming
        hold_phase <= 1'b1;
        for (int j = 0; j < 6; j++) random_line();
        hold_phase <= 1'b0;
        n += 6;
      end
      if (n == 80) begin
        in_valid <= 1'b0;
        wait (pending == 0);
        @(posedge clk);
      end
      random_line();
      idle_gap();
    end
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (pending != 0 && wait_cnt < 200000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (150) @(posedge clk);
    $display("Covered %0d lines, %0d corners checked, %0d of them degenerate.",
             lines_sent, corners_seen, degen_seen);
    $display("Long output hold-off and a full drain pause were both exercised.");
    if (fail_count == 0 && pending == 0) begin
      $display("** billboard_line_quad_expand_core: PASSED **");
    end else begin
      $display("** billboard_line_quad_expand_core: FAILED **");
    end
    $finish;
  end

  // Run limit
  initial begin
    #20ms;
    $display("Timeout with %0d corners still expected.", pending);
    $display("** billboard_line_quad_expand_core: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
